[rtl/core/lsfe_pkg.sv]
// ----------------------------------------------------------------------------
// LED sparkle fire effect package
// Shared widths, constants and command type for the fire effect unit.
// ----------------------------------------------------------------------------
package lsfe_pkg;

    localparam int POS_W   = 5;
    localparam int HEAT_W  = 8;
    localparam int IDX_W   = 5;
    localparam int CHAN_W  = 7;
    localparam int PHASE_W = 9;
    localparam int BRT_W   = 3;

    localparam int PIXEL_TOTAL_DEF = 32;

    localparam logic [HEAT_W-1:0]  COOL_STEP  = 8'd15;
    localparam logic [HEAT_W-1:0]  HEAT_LIMIT = 8'd50;
    localparam logic [9:0]         WHEEL_SPAN = 10'd384;
    localparam logic [PHASE_W-1:0] PHASE_MAX  = 9'd384;
    localparam logic [CHAN_W-1:0]  CHAN_MAX   = 7'd127;

    // Division by five as multiply by 205 and shift by 10, exact for 8-bit values.
    localparam logic [15:0] DIV5_MUL   = 16'd205;
    localparam int          DIV5_SHIFT = 10;

    localparam logic [BRT_W-1:0] BRT_RESET   = 3'd1;
    localparam logic [BRT_W-1:0] BRT_3Q      = 3'd2;
    localparam logic [BRT_W-1:0] BRT_HALF    = 3'd3;
    localparam logic [BRT_W-1:0] BRT_QUARTER = 3'd4;
    localparam logic [BRT_W-1:0] BRT_EIGHTH  = 3'd5;

    localparam logic [1:0] SEG_RED_GREEN  = 2'd0;
    localparam logic [1:0] SEG_GREEN_BLUE = 2'd1;

    typedef struct packed {
        logic spark_load;   // latch the spark of an accepted transfer
        logic spark_wr;     // write the spark into the heat buffer
        logic rd_en;        // read the cell addressed by the count
        logic shift;        // move the read cell into the previous-cell register
        logic calc_en;      // cool one cell, write it back and load stage one
        logic nbr_zero;     // right neighbor lies past the strip
        logic phase_step;   // advance the animation phase
    } t_cmd;

endpackage

[rtl/core/lsfe_spark_if.sv]
// ----------------------------------------------------------------------------
// Spark stream interface
// Valid/ready channel carrying one spark per frame tick.
// ----------------------------------------------------------------------------
interface lsfe_spark_if;

    logic                       valid;
    logic                       ready;
    logic [lsfe_pkg::POS_W-1:0]  spark_position;
    logic [lsfe_pkg::HEAT_W-1:0] spark_value;

    modport source (output valid, output spark_position, output spark_value, input ready);
    modport sink   (input valid, input spark_position, input spark_value, output ready);

endinterface

[rtl/core/lsfe_pixel_if.sv]
// ----------------------------------------------------------------------------
// Pixel stream interface
// Valid/ready channel carrying one colored pixel per transfer.
// ----------------------------------------------------------------------------
interface lsfe_pixel_if;

    logic                       valid;
    logic                       ready;
    logic [lsfe_pkg::IDX_W-1:0]  pixel_index;
    logic [lsfe_pkg::CHAN_W-1:0] red;
    logic [lsfe_pkg::CHAN_W-1:0] green;
    logic [lsfe_pkg::CHAN_W-1:0] blue;
    logic                       last_pixel;

    modport source (output valid, output pixel_index, output red, output green,
                    output blue, output last_pixel, input ready);
    modport sink   (input valid, input pixel_index, input red, input green,
                    input blue, input last_pixel, output ready);

endinterface

[rtl/core/lsfe_ctrl.sv]
// ----------------------------------------------------------------------------
// Fire effect controller
// Sequences the spark write and the walk over all heat cells of one frame.
// ----------------------------------------------------------------------------
module lsfe_ctrl #(
    parameter int PIXEL_TOTAL = lsfe_pkg::PIXEL_TOTAL_DEF,
    parameter int CW          = $clog2(PIXEL_TOTAL + 2)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_spark_valid,
    output logic            o_spark_ready,
    input  logic            i_adv,
    output lsfe_pkg::t_cmd  o_cmd,
    output logic [CW-1:0]   o_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPARK,
        ST_RUN
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic          w_accept;

    assign o_spark_ready = (r_state == ST_IDLE);
    assign w_accept      = i_spark_valid && o_spark_ready;
    assign o_count       = r_count;

    always_comb begin
        o_cmd            = '0;
        o_cmd.spark_load = w_accept;
        o_cmd.spark_wr   = (r_state == ST_SPARK);
        if (r_state == ST_RUN && i_adv) begin
            o_cmd.shift      = 1'b1;
            o_cmd.rd_en      = (r_count < CW'(PIXEL_TOTAL));
            o_cmd.calc_en    = (r_count >= CW'(2));
            o_cmd.nbr_zero   = (r_count == CW'(PIXEL_TOTAL + 1));
            o_cmd.phase_step = (r_count == CW'(PIXEL_TOTAL + 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_SPARK;
                    end
                end
                ST_SPARK: begin
                    r_count <= '0;
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (i_adv) begin
                        r_count <= r_count + CW'(1);
                        if (r_count == CW'(PIXEL_TOTAL + 1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/lsfe_dp.sv]
// ----------------------------------------------------------------------------
// Fire effect datapath
// Heat buffer, cooling stage, color wheel, dimming and output register.
// ----------------------------------------------------------------------------
module lsfe_dp #(
    parameter int PIXEL_TOTAL = lsfe_pkg::PIXEL_TOTAL_DEF,
    parameter int CW          = $clog2(PIXEL_TOTAL + 2),
    parameter int AW          = $clog2(PIXEL_TOTAL)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsfe_pkg::t_cmd                i_cmd,
    input  logic [CW-1:0]                 i_count,
    output logic                          o_adv,
    input  logic [lsfe_pkg::POS_W-1:0]    i_spark_position,
    input  logic [lsfe_pkg::HEAT_W-1:0]   i_spark_value,
    input  logic                          i_cfg_we,
    input  logic [lsfe_pkg::BRT_W-1:0]    i_cfg_wdata,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lsfe_pkg::IDX_W-1:0]    o_pixel_index,
    output logic [lsfe_pkg::CHAN_W-1:0]   o_red,
    output logic [lsfe_pkg::CHAN_W-1:0]   o_green,
    output logic [lsfe_pkg::CHAN_W-1:0]   o_blue,
    output logic                          o_last_pixel
);

    localparam int HW = lsfe_pkg::HEAT_W;
    localparam int CH = lsfe_pkg::CHAN_W;
    localparam int PW = lsfe_pkg::PHASE_W;

    function automatic logic [CH-1:0] dim_chan(input logic [CH-1:0] c,
                                               input logic [lsfe_pkg::BRT_W-1:0] lvl);
        logic [CH+1:0] t;
        t = (CH + 2)'(c) * (CH + 2)'(3);
        unique case (lvl)
            lsfe_pkg::BRT_3Q:      dim_chan = t[CH+1:2];
            lsfe_pkg::BRT_HALF:    dim_chan = c >> 1;
            lsfe_pkg::BRT_QUARTER: dim_chan = c >> 2;
            lsfe_pkg::BRT_EIGHTH:  dim_chan = c >> 3;
            default:               dim_chan = c;
        endcase
    endfunction

    // Heat buffer and its per-entry valid bits; an unwritten cell reads as zero.
    logic [HW-1:0]          r_heat_mem [PIXEL_TOTAL];
    logic [PIXEL_TOTAL-1:0] r_cell_vld;

    logic [lsfe_pkg::POS_W-1:0]  r_spark_pos;
    logic [HW-1:0]               r_spark_val;
    logic [lsfe_pkg::BRT_W-1:0]  r_brightness;
    logic [PW-1:0]               r_phase;

    logic [HW-1:0] r_rd_raw;
    logic          r_rd_vld;
    logic [HW-1:0] r_prev;

    logic          r_s1_valid;
    logic [HW-1:0] r_s1_heat;
    logic [AW-1:0] r_s1_idx;
    logic          r_s1_last;
    logic [PW-1:0] r_s1_phase;

    logic                        r_o_valid;
    logic [lsfe_pkg::IDX_W-1:0]  r_o_idx;
    logic [CH-1:0]               r_o_red;
    logic [CH-1:0]               r_o_green;
    logic [CH-1:0]               r_o_blue;
    logic                        r_o_last;

    logic          w_adv;
    logic          w_pos_ok;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_calc_idx;
    logic [HW-1:0] w_cur_cell;
    logic [HW-1:0] w_nbr;
    logic [HW:0]   w_pair_sum;
    logic [HW-1:0] w_avg;
    logic [HW-1:0] w_new_heat;
    logic          w_we;
    logic [AW-1:0] w_wr_addr;
    logic [HW-1:0] w_wr_data;

    logic [15:0]   w_prod;
    logic [9:0]    w_wheel_sum;
    logic [PW-1:0] w_wheel_pos;
    logic [CH-1:0] w_k;
    logic [CH-1:0] w_red;
    logic [CH-1:0] w_green;
    logic [CH-1:0] w_blue;
    logic          w_hot;

    // The pipeline moves whenever the output register is empty or being drained.
    assign w_adv = !r_o_valid || i_ready;
    assign o_adv = w_adv;

    // Cooling stage.
    assign w_pos_ok   = (32'(r_spark_pos) < PIXEL_TOTAL);
    assign w_rd_addr  = AW'(i_count);
    assign w_calc_idx = AW'(i_count - CW'(2));
    assign w_cur_cell = r_rd_vld ? r_rd_raw : '0;
    assign w_nbr      = i_cmd.nbr_zero ? '0 : w_cur_cell;
    assign w_pair_sum = (HW + 1)'(r_prev) + (HW + 1)'(w_nbr);
    assign w_avg      = w_pair_sum[HW:1];
    assign w_new_heat = (w_avg > lsfe_pkg::COOL_STEP) ? (w_avg - lsfe_pkg::COOL_STEP) : '0;

    always_comb begin
        w_we      = 1'b0;
        w_wr_addr = w_calc_idx;
        w_wr_data = w_new_heat;
        if (i_cmd.spark_wr) begin
            w_we      = w_pos_ok;
            w_wr_addr = AW'(r_spark_pos);
            w_wr_data = r_spark_val;
        end else if (i_cmd.calc_en) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_heat_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_raw <= r_heat_mem[w_rd_addr];
        end
    end

    // Color stage: wheel position (heat/5 + phase) mod 384.
    assign w_prod      = 16'(r_s1_heat) * lsfe_pkg::DIV5_MUL;
    assign w_wheel_sum = 10'(w_prod >> lsfe_pkg::DIV5_SHIFT) + 10'(r_s1_phase);
    assign w_wheel_pos = (w_wheel_sum >= lsfe_pkg::WHEEL_SPAN)
                         ? PW'(w_wheel_sum - lsfe_pkg::WHEEL_SPAN)
                         : PW'(w_wheel_sum);
    assign w_k         = w_wheel_pos[CH-1:0];
    assign w_hot       = (r_s1_heat > lsfe_pkg::HEAT_LIMIT);

    always_comb begin
        w_red   = '0;
        w_green = '0;
        w_blue  = '0;
        case (w_wheel_pos[PW-1:CH])
            lsfe_pkg::SEG_RED_GREEN: begin
                w_red   = lsfe_pkg::CHAN_MAX - w_k;
                w_green = w_k;
            end
            lsfe_pkg::SEG_GREEN_BLUE: begin
                w_green = lsfe_pkg::CHAN_MAX - w_k;
                w_blue  = w_k;
            end
            default: begin
                w_red  = w_k;
                w_blue = lsfe_pkg::CHAN_MAX - w_k;
            end
        endcase
        if (!w_hot) begin
            w_red   = '0;
            w_green = '0;
            w_blue  = '0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.spark_load) begin
            r_spark_pos <= i_spark_position;
            r_spark_val <= i_spark_value;
        end
        if (i_cmd.shift) begin
            r_prev <= w_cur_cell;
        end
        if (i_cmd.calc_en) begin
            r_s1_heat  <= w_new_heat;
            r_s1_idx   <= w_calc_idx;
            r_s1_last  <= (w_calc_idx == AW'(PIXEL_TOTAL - 1));
            r_s1_phase <= r_phase;
        end
        if (w_adv && r_s1_valid) begin
            r_o_idx   <= lsfe_pkg::IDX_W'(r_s1_idx);
            r_o_red   <= dim_chan(w_red, r_brightness);
            r_o_green <= dim_chan(w_green, r_brightness);
            r_o_blue  <= dim_chan(w_blue, r_brightness);
            r_o_last  <= r_s1_last;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_vld   <= '0;
            r_rd_vld     <= 1'b0;
            r_brightness <= lsfe_pkg::BRT_RESET;
            r_phase      <= '0;
            r_s1_valid   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (w_we) begin
                r_cell_vld[w_wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_cell_vld[w_rd_addr];
            end
            if (i_cfg_we) begin
                r_brightness <= i_cfg_wdata;
            end
            if (i_cmd.phase_step) begin
                r_phase <= (r_phase >= lsfe_pkg::PHASE_MAX) ? '0 : r_phase + PW'(1);
            end
            if (w_adv) begin
                r_s1_valid <= i_cmd.calc_en;
                r_o_valid  <= r_s1_valid;
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_pixel_index = r_o_idx;
    assign o_red         = r_o_red;
    assign o_green       = r_o_green;
    assign o_blue        = r_o_blue;
    assign o_last_pixel  = r_o_last;

endmodule

[rtl/core/led_sparkle_fire_effect_unit.sv]
// ----------------------------------------------------------------------------
// LED sparkle fire effect unit
// Heat-buffer fire animation producing one colored pixel per LED each frame.
// ----------------------------------------------------------------------------
// Each spark transfer is one frame tick: the spark lands in the heat buffer,
// every cell is cooled toward its right neighbor, and PIXEL_TOTAL pixels leave
// on the pixel channel in index order, the final one flagged by last_pixel.
// The controller takes the spark, writes it, and then walks the heat buffer one
// cell per cycle through the two-stage cooling and coloring pipeline. Stalls
// on the pixel channel freeze that walk. The next spark is taken once the walk
// ends, while the last pixels still drain. Brightness may be written between
// frames.
module led_sparkle_fire_effect_unit #(
    parameter int PIXEL_TOTAL = lsfe_pkg::PIXEL_TOTAL_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lsfe_spark_if.sink                  i_spark,
    lsfe_pixel_if.source                o_pixel,
    input  logic                        i_cfg_we,
    input  logic [lsfe_pkg::BRT_W-1:0]  i_cfg_wdata
);

    localparam int CW = $clog2(PIXEL_TOTAL + 2);
    localparam int AW = $clog2(PIXEL_TOTAL);

    lsfe_pkg::t_cmd w_cmd;
    logic [CW-1:0]  w_count;
    logic           w_adv;
    logic           w_spark_ready;
    logic           w_accept;

    assign i_spark.ready = w_spark_ready;
    assign w_accept      = i_spark.valid && w_spark_ready;

    lsfe_ctrl #(
        .PIXEL_TOTAL (PIXEL_TOTAL),
        .CW          (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_spark_valid (i_spark.valid),
        .o_spark_ready (w_spark_ready),
        .i_adv         (w_adv),
        .o_cmd         (w_cmd),
        .o_count       (w_count)
    );

    lsfe_dp #(
        .PIXEL_TOTAL (PIXEL_TOTAL),
        .CW          (CW),
        .AW          (AW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_count          (w_count),
        .o_adv            (w_adv),
        .i_spark_position (i_spark.spark_position),
        .i_spark_value    (i_spark.spark_value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_pixel.valid),
        .i_ready          (o_pixel.ready),
        .o_pixel_index    (o_pixel.pixel_index),
        .o_red            (o_pixel.red),
        .o_green          (o_pixel.green),
        .o_blue           (o_pixel.blue),
        .o_last_pixel     (o_pixel.last_pixel)
    );

    // A spark transfer raises the heat-buffer spark write on the very next cycle.
    a_spark_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_cmd.spark_wr)
        else $error("spark write did not follow the spark transfer");

    // No second spark is taken while a frame is in progress.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_spark.ready)
        else $error("spark channel ready right after a transfer");

    // The flagged pixel is always the final cell of the strip.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pixel.valid && o_pixel.last_pixel)
            |-> (o_pixel.pixel_index == lsfe_pkg::IDX_W'(PIXEL_TOTAL - 1)))
        else $error("last pixel flagged on the wrong index");

endmodule
